FILE: rtl/core/jsi_pkg.sv
`default_nettype none

package jsi_pkg;

    // Default configuration
    localparam int BYTES_PER_WORD_DEF = 8;
    localparam int POSITION_BITS_DEF  = 32;

    // Character codes
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;

    // Class bits: whitespace in the upper two, structural in the lower three
    localparam logic [4:0] WS_BITS = 5'h18;
    localparam logic [4:0] ST_BITS = 5'h07;

    localparam logic [4:0] HI_NIBBLE_CLASS [16] = '{
        5'd8, 5'd0, 5'd17, 5'd2, 5'd0, 5'd4, 5'd0, 5'd4,
        5'd0, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0, 5'd0, 5'd0
    };
    localparam logic [4:0] LO_NIBBLE_CLASS [16] = '{
        5'd16, 5'd0, 5'd0,  5'd0, 5'd0, 5'd0,  5'd0, 5'd0,
        5'd0,  5'd8, 5'd10, 5'd4, 5'd1, 5'd12, 5'd0, 5'd0
    };

    // Input request payload
    typedef struct packed {
        logic [63:0] data_bytes;
        logic [3:0]  byte_count;
        logic        last_word;
    } t_in_req;

    // Output request payload
    typedef struct packed {
        logic [31:0] position;
        logic        is_terminator;
        logic        unclosed_string;
        logic        last_of_run;
    } t_out_res;

    // Scanner state that ripples from byte to byte
    typedef struct packed {
        logic esc;
        logic in_str;
        logic prev_sep;
    } t_scan_carry;

    // Per-word flags handed to the merge stage
    typedef struct packed {
        logic last;
        logic unclosed;
    } t_word_flags;

    // Nibble-table character class; non-ASCII bytes have no class
    function automatic logic [4:0] class_of(input logic [7:0] c);
        logic [4:0] cls;
        cls = HI_NIBBLE_CLASS[c[7:4]] & LO_NIBBLE_CLASS[c[3:0]];
        if (c[7]) begin
            cls = '0;
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jsi_req_if.sv
`default_nettype none

interface jsi_req_if;
    logic             valid;
    logic             ready;
    jsi_pkg::t_in_req payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/jsi_res_if.sv
`default_nettype none

interface jsi_res_if;
    logic              valid;
    logic              ready;
    jsi_pkg::t_out_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/json_structural_indexer.sv
`default_nettype none

// JSON structural indexer. Text arrives as words of up to BYTES_PER_WORD bytes (byte 0
// first); the block returns the byte offset of every structural character outside strings
// (, : [ ] { }, the opening quote, and the first byte of each value that follows a
// separator or whitespace), one per output request, and on the last word a terminator
// carrying the total length and an unclosed-string flag. One lane per byte scans each
// word, with escape, string and separator state rippling through the lanes. The merge
// stage then gives one result per cycle unless the output stalls; a word with no result
// never stalls behind an idle merge stage, and the next word is taken in the cycle the
// previous word's final result moves to the output register. Positions wrap modulo
// 2^POSITION_BITS and state returns to its reset values after every last word.
module json_structural_indexer #(
    parameter int BYTES_PER_WORD = jsi_pkg::BYTES_PER_WORD_DEF,
    parameter int POSITION_BITS  = jsi_pkg::POSITION_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jsi_req_if.sink   i_req,
    jsi_res_if.source o_res
);

    localparam int CNT_W = $clog2(BYTES_PER_WORD + 1);

    // Scanner state
    logic                      r_esc;
    logic                      r_in_str;
    logic                      r_prev_sep;
    logic [POSITION_BITS-1:0]  r_pos;

    logic                      accept;
    logic                      merge_ready;
    logic                      load;
    logic [CNT_W-1:0]          eff_cnt;
    logic [POSITION_BITS-1:0]  n_pos;
    logic [BYTES_PER_WORD-1:0] lane_mark;
    jsi_pkg::t_scan_carry      scan_carry [BYTES_PER_WORD+1];
    jsi_pkg::t_word_flags      word_flags;

    // Clamp the byte count to the word size
    assign eff_cnt = (i_req.payload.byte_count > 4'(BYTES_PER_WORD))
                   ? CNT_W'(BYTES_PER_WORD) : CNT_W'(i_req.payload.byte_count);
    assign n_pos   = r_pos + POSITION_BITS'(eff_cnt);

    assign scan_carry[0].esc      = r_esc;
    assign scan_carry[0].in_str   = r_in_str;
    assign scan_carry[0].prev_sep = r_prev_sep;

    // Byte lanes
    for (genvar g = 0; g < BYTES_PER_WORD; g++) begin : g_lane
        jsi_lane u_lane (
            .i_byte  (i_req.payload.data_bytes[8*g +: 8]),
            .i_en    (eff_cnt > CNT_W'(g)),
            .i_carry (scan_carry[g]),
            .o_carry (scan_carry[g+1]),
            .o_mark  (lane_mark[g])
        );
    end

    assign accept      = i_req.valid && merge_ready;
    assign i_req.ready = merge_ready;
    assign load        = accept && ((|lane_mark) || i_req.payload.last_word);

    assign word_flags.last     = i_req.payload.last_word;
    assign word_flags.unclosed = scan_carry[BYTES_PER_WORD].in_str;

    // State update; a last word restores the start-of-document state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc      <= 1'b0;
            r_in_str   <= 1'b0;
            r_prev_sep <= 1'b1;
            r_pos      <= '0;
        end else if (accept) begin
            if (i_req.payload.last_word) begin
                r_esc      <= 1'b0;
                r_in_str   <= 1'b0;
                r_prev_sep <= 1'b1;
                r_pos      <= '0;
            end else begin
                r_esc      <= scan_carry[BYTES_PER_WORD].esc;
                r_in_str   <= scan_carry[BYTES_PER_WORD].in_str;
                r_prev_sep <= scan_carry[BYTES_PER_WORD].prev_sep;
                r_pos      <= n_pos;
            end
        end
    end

    jsi_merge #(
        .BYTES_PER_WORD (BYTES_PER_WORD),
        .POSITION_BITS  (POSITION_BITS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_mask  (lane_mark),
        .i_base  (r_pos),
        .i_end   (n_pos),
        .i_flags (word_flags),
        .o_ready (merge_ready),
        .o_res   (o_res)
    );

    // Checks
    a_doc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.payload.last_word |=>
            (r_pos == '0) && !r_in_str && !r_esc && r_prev_sep)
        else $error("scanner state not restored after last word");

    a_term_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.payload.is_terminator |-> o_res.payload.last_of_run)
        else $error("terminator is not the final result of its word");

    a_unclosed_on_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.payload.unclosed_string |-> o_res.payload.is_terminator)
        else $error("unclosed flag on a non-terminator result");

    a_empty_word_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_req.payload.last_word && (lane_mark == '0) |-> !load)
        else $error("word without results loaded into merge stage");

endmodule

`default_nettype wire

FILE: rtl/core/jsi_lane.sv
`default_nettype none

// One byte of the scanner: classify, update escape/string/separator state, flag a mark
module jsi_lane (
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_en,
    input  wire jsi_pkg::t_scan_carry i_carry,
    output jsi_pkg::t_scan_carry      o_carry,
    output logic                      o_mark
);

    logic       is_bs;
    logic       quote;
    logic       lit;
    logic       ws;
    logic       st;
    logic       pseudo;
    logic [4:0] cls;

    assign cls    = jsi_pkg::class_of(i_byte);
    assign is_bs  = (i_byte == jsi_pkg::CHAR_BACKSLASH);
    assign quote  = (i_byte == jsi_pkg::CHAR_QUOTE) && !i_carry.esc;
    assign lit    = i_carry.in_str ^ quote;
    assign ws     = (|(cls & jsi_pkg::WS_BITS)) && !lit;
    assign st     = (|(cls & jsi_pkg::ST_BITS)) && !lit;
    assign pseudo = i_carry.prev_sep && !ws && !lit;

    // Disabled lanes (past byte_count) pass the state through untouched
    always_comb begin
        if (i_en) begin
            o_carry.esc      = is_bs && !i_carry.esc;
            o_carry.in_str   = lit;
            o_carry.prev_sep = st || ws;
            // closing quote is never reported
            o_mark           = (st || quote || pseudo) && !(quote && !lit);
        end else begin
            o_carry = i_carry;
            o_mark  = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/jsi_merge.sv
`default_nettype none

// Holds a word's mark mask; hands out one result per cycle when the output is free,
// lowest byte first, then the terminator on a last word
module jsi_merge #(
    parameter int BYTES_PER_WORD = jsi_pkg::BYTES_PER_WORD_DEF,
    parameter int POSITION_BITS  = jsi_pkg::POSITION_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic [BYTES_PER_WORD-1:0] i_mask,
    input  wire logic [POSITION_BITS-1:0]  i_base,
    input  wire logic [POSITION_BITS-1:0]  i_end,
    input  wire jsi_pkg::t_word_flags      i_flags,
    output logic                           o_ready,
    jsi_res_if.source                      o_res
);

    localparam int IDX_W = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;

    // Pending word
    logic                      r_w_valid;
    logic [BYTES_PER_WORD-1:0] r_mask;
    logic [POSITION_BITS-1:0]  r_base;
    logic [POSITION_BITS-1:0]  r_end;
    jsi_pkg::t_word_flags      r_flags;

    // Output register
    logic                      r_o_valid;
    jsi_pkg::t_out_res         r_o_res;

    logic                      o_free;
    logic                      step;
    logic                      any_mark;
    logic                      final_res;
    logic [IDX_W-1:0]          sel;
    logic [BYTES_PER_WORD-1:0] mask_rest;
    logic [POSITION_BITS-1:0]  mark_pos;
    jsi_pkg::t_out_res         n_res;

    // Lowest set mark
    always_comb begin
        sel = '0;
        for (int i = BYTES_PER_WORD - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = IDX_W'(i);
            end
        end
    end

    assign any_mark  = |r_mask;
    assign mask_rest = r_mask & (r_mask - BYTES_PER_WORD'(1));
    assign mark_pos  = r_base + POSITION_BITS'(sel);

    // Next result: a mark if any is left, otherwise the terminator
    always_comb begin
        if (any_mark) begin
            final_res             = (mask_rest == '0) && !r_flags.last;
            n_res.position        = 32'(mark_pos);
            n_res.is_terminator   = 1'b0;
            n_res.unclosed_string = 1'b0;
            n_res.last_of_run     = final_res;
        end else begin
            final_res             = 1'b1;
            n_res.position        = 32'(r_end);
            n_res.is_terminator   = 1'b1;
            n_res.unclosed_string = r_flags.unclosed;
            n_res.last_of_run     = 1'b1;
        end
    end

    assign o_free  = !r_o_valid || o_res.ready;
    assign step    = r_w_valid && o_free;
    assign o_ready = !r_w_valid || (step && final_res);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (step) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
            if (i_load) begin
                r_w_valid <= 1'b1;
            end else if (step && final_res) begin
                r_w_valid <= 1'b0;
            end
        end
    end

    // Payload; a new word replaces whatever mask is left
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_o_res <= n_res;
        end
        if (i_load) begin
            r_mask  <= i_mask;
            r_base  <= i_base;
            r_end   <= i_end;
            r_flags <= i_flags;
        end else if (step) begin
            r_mask  <= mask_rest;
        end
    end

    assign o_res.valid   = r_o_valid;
    assign o_res.payload = r_o_res;

endmodule

`default_nettype wire
